// ----- rtl/wlt_pkg.sv -----
// ----------------------------------------------------------------------------
// Wake lock table package
// Command, status and sleep kind codes, controller state and shared structs.
// ----------------------------------------------------------------------------
package wlt_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_LOCK   = 3'd2,
    CMD_UNLOCK = 3'd3,
    CMD_SETPRM = 3'd4,
    CMD_SLEEP  = 3'd5,
    CMD_TICK   = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOTUSED = 3'd1,
    ST_BADHDL  = 3'd2,
    ST_FULL    = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  localparam logic [1:0] KIND_HARD   = 2'd0;
  localparam logic [1:0] KIND_TIMED  = 2'd1;
  localparam logic [1:0] KIND_REMOTE = 2'd2;

  localparam logic [1:0] REG_SLEEP_EN = 2'd0;
  localparam logic [1:0] REG_OLD_BRD  = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;

  localparam logic [31:0] PERIOD_SINGLE = 32'hFFFF_FFFF;
  localparam logic [7:0]  WINDOW_RESET  = 8'd30;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic exec;       // run table or sleep command
    logic walk_start; // reset entry walk
    logic walk_load;  // set up modulo for current entry
    logic div_step;   // one restoring division step
    logic walk_next;  // finish current entry, advance
    logic out_load;   // drive output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_walk;    // command needs entry walk
    logic need_div;   // current entry needs modulo
    logic div_done;
    logic walk_last;
  } sts_t;

endpackage

// ----- rtl/wake_lock_table_with_periodic_wake.sv -----
// ----------------------------------------------------------------------------
// Wake lock table with periodic wake
// Top level: config registers, output handshake, controller and datapath.
// ----------------------------------------------------------------------------
// Flow: a word taken in S_IDLE is captured, then run in S_EXEC for table and
// sleep commands, and its result loads into the output registers in S_OUT once
// the output is free. A time tick walks every entry in S_WALK instead, running
// the 32-step serial modulo in S_DIV per timed entry when low voltage is clear.
// One word in flight; the next word waits for the result load (and any stall).
// Reset: asynchronous active low; table empty, links -1, window 30.
module wake_lock_table_with_periodic_wake
  import wlt_pkg::*;
#(
  parameter int LOCK_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        cmd_i,
  input  logic signed [7:0] handle_i,
  input  logic [31:0]       start_time_i,
  input  logic [31:0]       period_i,
  input  logic signed [3:0] link_id_i,
  input  logic              keep_link_i,
  input  logic [31:0]       now_time_i,
  input  logic              low_volt_i,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status_o,
  output logic [2:0]        new_handle_o,
  output logic [1:0]        sleep_kind_o,
  output logic [7:0]        due_mask_o,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);

  ctl_t ctl;
  sts_t sts;
  logic sleep_en_q, old_brd_q;
  logic [7:0] window_q;
  logic out_valid_q;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_en_q <= 1'b0;
      old_brd_q  <= 1'b0;
      window_q   <= WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        REG_SLEEP_EN: sleep_en_q <= cfg_data_i[0];
        REG_OLD_BRD:  old_brd_q  <= cfg_data_i[0];
        REG_WINDOW:   window_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  wlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_free_i (!out_valid_q || !out_stall),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  wlt_dpath #(.LOCK_COUNT(LOCK_COUNT)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .sleep_enable_i (sleep_en_q),
    .old_board_i    (old_brd_q),
    .wake_window_i  (window_q),
    .cmd_i          (cmd_i),
    .handle_i       (handle_i),
    .start_time_i   (start_time_i),
    .period_i       (period_i),
    .link_id_i      (link_id_i),
    .keep_link_i    (keep_link_i),
    .now_time_i     (now_time_i),
    .low_volt_i     (low_volt_i),
    .status_o       (status_o),
    .new_handle_o   (new_handle_o),
    .sleep_kind_o   (sleep_kind_o),
    .due_mask_o     (due_mask_o)
  );

endmodule

// ----- rtl/wlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wake lock table controller
// Sequences command capture, entry walk, modulo steps and result handoff.
// ----------------------------------------------------------------------------
module wlt_ctrl
  import wlt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_free_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  assign in_stall = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_walk) begin
          ctl_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end else begin
          ctl_o.exec = 1'b1;
          state_d    = S_OUT;
        end
      end
      S_WALK: begin
        if (sts_i.need_div) begin
          ctl_o.walk_load = 1'b1;
          state_d         = S_DIV;
        end else begin
          ctl_o.walk_next = 1'b1;
          if (sts_i.walk_last) state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          ctl_o.walk_next = 1'b1;
          state_d = sts_i.walk_last ? S_OUT : S_WALK;
        end else begin
          ctl_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/wlt_dpath.sv -----
// ----------------------------------------------------------------------------
// Wake lock table datapath
// Entry table, command execution, per-entry walk and serial 32-bit modulo.
// ----------------------------------------------------------------------------
module wlt_dpath
  import wlt_pkg::*;
#(
  parameter int LOCK_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  output sts_t              sts_o,
  input  logic              sleep_enable_i,
  input  logic              old_board_i,
  input  logic [7:0]        wake_window_i,
  input  logic [2:0]        cmd_i,
  input  logic signed [7:0] handle_i,
  input  logic [31:0]       start_time_i,
  input  logic [31:0]       period_i,
  input  logic signed [3:0] link_id_i,
  input  logic              keep_link_i,
  input  logic [31:0]       now_time_i,
  input  logic              low_volt_i,
  output logic [2:0]        status_o,
  output logic [2:0]        new_handle_o,
  output logic [1:0]        sleep_kind_o,
  output logic [7:0]        due_mask_o
);

  localparam int IW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CW = $clog2(LOCK_COUNT + 1);

  // entry table
  logic [LOCK_COUNT-1:0]    in_use_q, locked_q, keep_q;
  logic signed [3:0]        link_q  [LOCK_COUNT];
  logic [31:0]              start_q [LOCK_COUNT];
  logic [31:0]              per_q   [LOCK_COUNT];
  logic [31:0]              last_q  [LOCK_COUNT];

  // captured input word
  logic [2:0]               cmd_q;
  logic signed [7:0]        hdl_q;
  logic [31:0]              st_in_q, per_in_q, now_q;
  logic signed [3:0]        link_in_q;
  logic                     keep_in_q, low_q;

  // result
  logic [2:0]               res_status_q;
  logic [2:0]               res_newh_q;
  logic [1:0]               res_kind_q;
  logic [7:0]               res_due_q;

  // walk and divider
  logic [CW-1:0]            idx_q;
  logic [IW-1:0]            idx;
  logic [31:0]              rem_q, quo_q, div_q;
  logic [5:0]               dcnt_q;
  logic [32:0]              trial;
  logic                     hdl_ok;
  logic [IW-1:0]            h;
  logic                     free_found;
  logic [IW-1:0]            free_idx;
  logic                     any_lock, any_timed, any_remote;
  logic                     due_now;

  assign idx = idx_q[IW-1:0];
  assign h   = hdl_q[IW-1:0];
  assign hdl_ok = !hdl_q[7] && ({24'd0, hdl_q} < 32'(LOCK_COUNT));

  // first free entry and sleep summary
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    any_lock   = 1'b0;
    any_timed  = 1'b0;
    any_remote = 1'b0;
    for (int i = LOCK_COUNT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
      if (in_use_q[i]) begin
        if (locked_q[i]) any_lock = 1'b1;
        if (start_q[i] != 32'd0) any_timed = 1'b1;
        if (!link_q[i][3] && keep_q[i] && !old_board_i) any_remote = 1'b1;
      end
    end
  end

  assign sts_o.is_walk   = (cmd_q == CMD_TICK);
  assign sts_o.need_div  = in_use_q[idx] && (start_q[idx] != 32'd0) && !low_q;
  assign sts_o.div_done  = (dcnt_q == 6'd32);
  assign sts_o.walk_last = (idx_q == CW'(LOCK_COUNT - 1));

  assign trial = {rem_q, quo_q[31]} - {1'b0, div_q};

  // due decision after modulo (or low voltage)
  always_comb begin
    if (!in_use_q[idx] || start_q[idx] == 32'd0) due_now = 1'b0;
    else if (low_q) due_now = 1'b1;
    else due_now = (rem_q < {24'd0, wake_window_i}) &&
                   ((now_q - last_q[idx]) >= {24'd0, wake_window_i});
  end

  // table and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      locked_q <= '0;
      keep_q   <= '0;
      for (int i = 0; i < LOCK_COUNT; i++) begin
        link_q[i]  <= -4'sd1;
        start_q[i] <= '0;
        per_q[i]   <= '0;
        last_q[i]  <= '0;
      end
      idx_q       <= '0;
      dcnt_q      <= '0;
      status_o    <= '0;
      new_handle_o <= '0;
      sleep_kind_o <= '0;
      due_mask_o  <= '0;
      res_status_q <= '0;
      res_newh_q  <= '0;
      res_kind_q  <= '0;
      res_due_q   <= '0;
    end else begin
      if (ctl_i.load) begin
        res_status_q <= ST_OK;
        res_newh_q   <= '0;
        res_kind_q   <= KIND_HARD;
        res_due_q    <= '0;
      end
      // table and sleep commands (no walk)
      if (ctl_i.exec) begin
        case (cmd_q)
          CMD_CREATE: begin
            if (free_found) begin
              in_use_q[free_idx] <= 1'b1;
              locked_q[free_idx] <= 1'b0;
              keep_q[free_idx]   <= 1'b0;
              link_q[free_idx]   <= -4'sd1;
              start_q[free_idx]  <= '0;
              per_q[free_idx]    <= '0;
              last_q[free_idx]   <= '0;
              res_newh_q <= 3'(free_idx);
            end else begin
              res_status_q <= ST_FULL;
            end
          end
          CMD_DELETE, CMD_LOCK, CMD_UNLOCK, CMD_SETPRM: begin
            if (!hdl_ok) res_status_q <= ST_BADHDL;
            else if (!in_use_q[h])
              res_status_q <= (cmd_q == CMD_SETPRM) ? ST_BADHDL : ST_NOTUSED;
            else if (cmd_q == CMD_DELETE) begin
              in_use_q[h] <= 1'b0;
              locked_q[h] <= 1'b0;
            end else if (cmd_q == CMD_LOCK) locked_q[h] <= 1'b1;
            else if (cmd_q == CMD_UNLOCK) locked_q[h] <= 1'b0;
            else begin
              keep_q[h]  <= keep_in_q;
              link_q[h]  <= link_in_q;
              per_q[h]   <= (per_in_q == 32'd0) ? PERIOD_SINGLE : per_in_q;
              start_q[h] <= st_in_q;
              last_q[h]  <= st_in_q;
            end
          end
          CMD_SLEEP: begin
            if (!sleep_enable_i || any_lock) res_status_q <= ST_REFUSED;
            else if (any_remote) res_kind_q <= KIND_REMOTE;
            else if (any_timed) res_kind_q <= KIND_TIMED;
          end
          default: ;
        endcase
      end
      // entry walk
      if (ctl_i.walk_start) idx_q <= '0;
      if (ctl_i.walk_load) dcnt_q <= '0;
      if (ctl_i.div_step) dcnt_q <= dcnt_q + 6'd1;
      if (ctl_i.walk_next) begin
        if (due_now) begin
          last_q[idx] <= now_q;
          if (32'(idx_q) < 32'd8) res_due_q[3'(idx_q)] <= 1'b1;
        end
        idx_q <= idx_q + CW'(1);
      end
      // result handoff
      if (ctl_i.out_load) begin
        status_o     <= res_status_q;
        new_handle_o <= res_newh_q;
        sleep_kind_o <= res_kind_q;
        due_mask_o   <= res_due_q;
      end
    end
  end

  // input word and divider payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q     <= cmd_i;
      hdl_q     <= handle_i;
      st_in_q   <= start_time_i;
      per_in_q  <= period_i;
      link_in_q <= link_id_i;
      keep_in_q <= keep_link_i;
      now_q     <= now_time_i;
      low_q     <= low_volt_i;
    end
    if (ctl_i.walk_load) begin
      rem_q <= '0;
      quo_q <= now_q - start_q[idx];
      div_q <= (per_q[idx] == 32'd0) ? PERIOD_SINGLE : per_q[idx];
    end
    // one restoring step: shift in dividend bit, subtract if fits
    if (ctl_i.div_step) begin
      if (!trial[32]) rem_q <= trial[31:0];
      else rem_q <= {rem_q[30:0], quo_q[31]};
      quo_q <= {quo_q[30:0], 1'b0};
    end
  end

endmodule
